// ----- rtl/core/identifier_interning_hash_table_macros.svh -----
// assertion macros for the identifier interning hash table
// used by the rtl files that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef IDENTIFIER_INTERNING_HASH_TABLE_MACROS_SVH
`define IDENTIFIER_INTERNING_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define IHT_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("iht check failed");
`define IHT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("iht check failed");
`else
`define IHT_ASSERT(label, cond)
`define IHT_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/core/iht_pkg.sv -----
// shared constants, types and codes of the identifier interning hash table
// no dependencies
`default_nettype none
package iht_pkg;
  localparam int StoreDepth = 1024;
  localparam int BucketCount = 64;
  localparam int MaxNameLen = 12;
  localparam int PoolDepth = 256;

  localparam int CharW = 8;
  localparam int LineW = 16;
  localparam int StatusW = 3;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam int FreeW = StoreAw + 1;
  localparam int BucketW = $clog2(BucketCount);
  localparam int PoolAw = $clog2(PoolDepth);
  localparam int LinkW = PoolAw + 1;
  localparam int LenW = $clog2(MaxNameLen + 2);
  localparam int SumW = $clog2(MaxNameLen * 255 + 1);

  typedef enum logic [StatusW-1:0] {
    StAdded    = 3'd0,
    StPresent  = 3'd1,
    StTooLong  = 3'd2,
    StOverflow = 3'd3,
    StPoolFull = 3'd4
  } status_e;

  // one closed identifier handed from front to back
  typedef struct packed {
    logic [MaxNameLen-1:0][CharW-1:0] chars;
    logic [LenW-1:0]                  len;
    logic [SumW-1:0]                  sum;
    logic                             too_long;
    logic [LineW-1:0]                 line;
  } job_t;
endpackage
`default_nettype wire

// ----- rtl/core/iht_if.sv -----
// valid/ready channel interfaces for characters in and results out
// depends on iht_pkg
`default_nettype none
interface iht_in_if import iht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             is_last;
  logic [LineW-1:0] source_line;
  modport source (output valid, char_code, is_last, source_line, input ready);
  modport sink (input valid, char_code, is_last, source_line, output ready);
endinterface

interface iht_out_if import iht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [StoreAw-1:0] name_position;
  logic [BucketW-1:0] bucket_code;
  modport source (output valid, status, name_position, bucket_code, input ready);
  modport sink (input valid, status, name_position, bucket_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/iht_front.sv -----
// front: gathers characters of one identifier, sums codes, closes a job on the last one
// depends on iht_pkg
`default_nettype none
module iht_front import iht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [CharW-1:0] char_code_i,
  input  wire logic             is_last_i,
  input  wire logic [LineW-1:0] source_line_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output job_t                  job_o
);
  logic [LenW-1:0]                  len_q, len_d;
  logic [SumW-1:0]                  sum_q, sum_d;
  logic [MaxNameLen-1:0][CharW-1:0] buf_q, buf_d;
  logic                             xfer;

  assign ready_o = !full_i;
  assign xfer    = valid_i && ready_o;

  always_comb begin
    len_d = len_q;
    sum_d = sum_q;
    buf_d = buf_q;
    // length saturates one past the limit
    if (len_q <= LenW'(MaxNameLen)) begin
      len_d = len_q + LenW'(1);
      if (len_d <= LenW'(MaxNameLen)) begin
        buf_d[len_q] = char_code_i;
        sum_d = sum_q + SumW'(char_code_i);
      end
    end
  end

  assign push_o         = xfer && is_last_i;
  assign job_o.chars    = buf_d;
  assign job_o.len      = len_d;
  assign job_o.sum      = sum_d;
  assign job_o.too_long = len_d > LenW'(MaxNameLen);
  assign job_o.line     = source_line_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      sum_q <= '0;
    end else if (xfer) begin
      if (is_last_i) begin
        len_q <= '0;
        sum_q <= '0;
      end else begin
        len_q <= len_d;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      buf_q <= buf_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/iht_fifo.sv -----
// two-entry job queue between front and back
// depends on iht_pkg
`default_nettype none
module iht_fifo import iht_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);
  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/iht_back.sv -----
// back: walks the bucket chain, compares stored names, links new entries, drives results
// depends on iht_pkg and the macros header
`default_nettype none
`include "identifier_interning_hash_table_macros.svh"
module iht_back import iht_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire job_t               job_i,
  output logic                    pop_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [StoreAw-1:0]      name_position_o,
  output logic [BucketW-1:0]      bucket_code_o
);
  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SClass = 9'b000000010,
    SHead  = 9'b000000100,
    SWalk  = 9'b000001000,
    SEnt   = 9'b000010000,
    SCrd   = 9'b000100000,
    SCcmp  = 9'b001000000,
    SWr    = 9'b010000000,
    SOut   = 9'b100000000
  } state_e;

  state_e state_q;
  job_t   job_q;

  logic [CharW-1:0]   store_mem [StoreDepth];
  logic [LinkW-1:0]   head_mem [BucketCount];
  logic [StoreAw-1:0] start_mem [PoolDepth];
  logic [LineW-1:0]   line_mem [PoolDepth];
  logic [LinkW-1:0]   next_mem [PoolDepth];
  logic [BucketCount-1:0] head_vld_q;

  logic [CharW-1:0]   store_rd_q;
  logic [LinkW-1:0]   head_rd_q;
  logic [StoreAw-1:0] start_rd_q;
  logic [LinkW-1:0]   next_rd_q;

  logic [FreeW-1:0]   free_q;
  logic [LinkW-1:0]   count_q, link_q, steps_q, head_q;
  logic [BucketW-1:0] code_q;
  logic [StoreAw-1:0] s_q;
  logic [LenW-1:0]    k_q;
  logic [StatusW-1:0] res_status_q;
  logic [StoreAw-1:0] res_pos_q;
  logic [BucketW-1:0] res_code_q;

  logic [BucketW-1:0] code_c;
  logic [CharW-1:0]   b_c, w_c;
  logic               walk_go, add_c;
  logic [StoreAw-1:0] wr_addr_c;

  assign code_c  = job_q.sum[BucketW-1:0];
  assign b_c     = (k_q < job_q.len) ? job_q.chars[k_q] : '0;
  assign w_c     = (k_q < job_q.len) ? job_q.chars[k_q] : '0;
  assign walk_go = (link_q < count_q) && (steps_q < count_q);
  assign add_c   = (state_q == SWalk) && !walk_go && (count_q < LinkW'(PoolDepth));
  assign wr_addr_c = StoreAw'(free_q + FreeW'(k_q));

  assign pop_o           = (state_q == SIdle) && !empty_i;
  assign valid_o         = state_q == SOut;
  assign status_o        = res_status_q;
  assign name_position_o = res_pos_q;
  assign bucket_code_o   = res_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      free_q     <= '0;
      count_q    <= '0;
      head_vld_q <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (!empty_i) state_q <= SClass;
        end
        SClass: begin
          if (job_q.too_long ||
              (free_q + FreeW'(job_q.len)) >= FreeW'(StoreDepth)) begin
            state_q <= SOut;
          end else begin
            state_q <= SHead;
          end
        end
        SHead: state_q <= SWalk;
        SWalk: begin
          if (walk_go) begin
            state_q <= SEnt;
          end else if (add_c) begin
            head_vld_q[code_q] <= 1'b1;
            state_q <= SWr;
          end else begin
            state_q <= SOut;
          end
        end
        SEnt: state_q <= SCrd;
        SCrd: state_q <= SCcmp;
        SCcmp: begin
          if (store_rd_q != b_c || store_rd_q == '0 ||
              k_q == LenW'(MaxNameLen + 1)) begin
            state_q <= (store_rd_q == b_c && store_rd_q == '0) ? SOut : SWalk;
          end else begin
            state_q <= SCrd;
          end
        end
        SWr: begin
          // chars then the end marker
          if (k_q == job_q.len) begin
            free_q  <= free_q + FreeW'(job_q.len) + FreeW'(1);
            count_q <= count_q + LinkW'(1);
            state_q <= SOut;
          end
        end
        SOut: begin
          if (ready_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        job_q <= job_i;
      end
      SClass: begin
        code_q <= code_c;
        if (job_q.too_long) begin
          res_status_q <= StTooLong;
          res_pos_q    <= '0;
          res_code_q   <= '0;
        end else begin
          res_status_q <= StOverflow;
          res_pos_q    <= '0;
          res_code_q   <= '0;
        end
      end
      SHead: begin
        head_q  <= head_vld_q[code_q] ? head_rd_q : LinkW'(PoolDepth);
        link_q  <= head_vld_q[code_q] ? head_rd_q : LinkW'(PoolDepth);
        steps_q <= '0;
      end
      SWalk: begin
        k_q <= '0;
        if (!walk_go) begin
          res_status_q <= add_c ? StAdded : StPoolFull;
          res_pos_q    <= add_c ? free_q[StoreAw-1:0] : '0;
          res_code_q   <= code_q;
        end
      end
      SEnt: begin
        s_q <= start_rd_q;
        k_q <= '0;
      end
      SCcmp: begin
        k_q <= k_q + LenW'(1);
        if (store_rd_q != b_c || k_q == LenW'(MaxNameLen + 1)) begin
          link_q  <= next_rd_q;
          steps_q <= steps_q + LinkW'(1);
        end
        if (store_rd_q == b_c && store_rd_q == '0) begin
          res_status_q <= StPresent;
          res_pos_q    <= s_q;
          res_code_q   <= code_q;
        end
      end
      SWr: begin
        k_q <= k_q + LenW'(1);
      end
      default: ;
    endcase
  end

  // string store
  always_ff @(posedge clk_i) begin
    if (state_q == SWr) begin
      store_mem[wr_addr_c] <= w_c;
    end
    store_rd_q <= store_mem[StoreAw'(s_q + StoreAw'(k_q))];
  end

  // bucket heads
  always_ff @(posedge clk_i) begin
    if (add_c) begin
      head_mem[code_q] <= count_q;
    end
    head_rd_q <= head_mem[code_c];
  end

  // entry pool
  always_ff @(posedge clk_i) begin
    if (add_c) begin
      start_mem[count_q[PoolAw-1:0]] <= free_q[StoreAw-1:0];
      line_mem[count_q[PoolAw-1:0]]  <= job_q.line;
      next_mem[count_q[PoolAw-1:0]]  <= head_q;
    end
    start_rd_q <= start_mem[link_q[PoolAw-1:0]];
    next_rd_q  <= next_mem[link_q[PoolAw-1:0]];
  end

  `IHT_ASSERT(a_count_bound, count_q <= LinkW'(PoolDepth))
  `IHT_ASSERT(a_free_bound, free_q <= FreeW'(StoreDepth))
  `IHT_ASSERT(a_cmp_index, (state_q != SCcmp) || (k_q <= LenW'(MaxNameLen + 1)))
  `IHT_ASSERT_NEXT(a_add_writes, add_c, state_q == SWr && head_vld_q[code_q])
endmodule
`default_nettype wire

// ----- rtl/core/identifier_interning_hash_table.sv -----
// identifier interning hash table: one character per transfer, one result per identifier
// front takes a character every cycle while its two-entry job queue has room
// back: too-long or overflowing names go straight to the result; else a head read,
// then per visited entry a read and a char compare loop; len+1 store writes on an add
// result leaves after the output handshake; reset empties all buckets through valid bits
`default_nettype none
module identifier_interning_hash_table import iht_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iht_in_if.sink     in_chan_i,
  iht_out_if.source  out_chan_o
);
  logic full, push, pop, empty;
  job_t job_in, job_out;

  iht_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_chan_i.valid),
    .ready_o       (in_chan_i.ready),
    .char_code_i   (in_chan_i.char_code),
    .is_last_i     (in_chan_i.is_last),
    .source_line_i (in_chan_i.source_line),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in)
  );

  iht_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  iht_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (job_out),
    .pop_o           (pop),
    .valid_o         (out_chan_o.valid),
    .ready_i         (out_chan_o.ready),
    .status_o        (out_chan_o.status),
    .name_position_o (out_chan_o.name_position),
    .bucket_code_o   (out_chan_o.bucket_code)
  );
endmodule
`default_nettype wire
